// File: rtl/mbet_pkg.sv
`timescale 1ns / 1ps
// Package for the escape-time pixel engine: widths, constants, types and helpers.
// Used by every module of the block; it depends on nothing else.
package mbet_pkg;

    // Coordinate format: signed Q4.28 in 32 bits.
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 28;
    localparam int STEP_W     = 31;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 12;
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Default image side, handed to the top level parameter.
    localparam int MAX_SIDE_DEF = 4096;

    // Sums before saturation are carried in this many bits.
    localparam int SAT_W = 45;

    localparam logic signed [SAT_W-1:0] SAT_HI =
        SAT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    // Escape bound: four in Q8.56.
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(64'd4 << (2 * FRAC_BITS));

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(100);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_RE = 2'd0,
        CFG_ORIGIN_IM = 2'd1,
        CFG_STEP      = 2'd2,
        CFG_LIMIT     = 2'd3
    } cfg_reg_t;

    // Configuration as seen by the sequencer.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_re;
        logic signed [COORD_BITS-1:0] origin_im;
        logic [STEP_W-1:0]            step;
        logic [CNT_W-1:0]             limit;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C_RE,
        ST_C_IM,
        ST_C_SUM,
        ST_SQ_X,
        ST_SQ_Y,
        ST_CROSS,
        ST_UPDATE
    } state_t;

    // What the shared multiplier is given in a cycle.
    typedef enum logic [2:0] {
        MUL_STEP_COL,
        MUL_STEP_ROW,
        MUL_XX,
        MUL_YY,
        MUL_XY
    } mul_sel_t;

    // Clamp a wide signed sum to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SAT_W-1:0] v
    );
        if (v > SAT_HI) begin
            return COORD_BITS'(SAT_HI);
        end
        else if (v < SAT_LO) begin
            return COORD_BITS'(SAT_LO);
        end
        return COORD_BITS'(v);
    endfunction

endpackage

// File: rtl/mbet_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: origin, pixel step and iteration limit.
// Depends on mbet_pkg for the register indexes and the cfg_t struct.
module mbet_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0] cfg_data,
    output mbet_pkg::cfg_t             cfg
);
    import mbet_pkg::*;

    logic signed [COORD_BITS-1:0] origin_re_reg;
    logic signed [COORD_BITS-1:0] origin_im_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [CNT_W-1:0]             limit_reg;

    // Writes are always taken at once.
    assign cfg_ready = 1'b1;

    // Register writes by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_re_reg <= '0;
            origin_im_reg <= '0;
            step_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ORIGIN_RE: origin_re_reg <= $signed(cfg_data[COORD_BITS-1:0]);
                CFG_ORIGIN_IM: origin_im_reg <= $signed(cfg_data[COORD_BITS-1:0]);
                CFG_STEP:      step_reg      <= cfg_data[STEP_W-1:0];
                CFG_LIMIT:     limit_reg     <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.origin_re = origin_re_reg;
    assign cfg.origin_im = origin_im_reg;
    assign cfg.step      = step_reg;
    assign cfg.limit     = limit_reg;

endmodule

// File: rtl/mbet_mul.sv
`timescale 1ns / 1ps
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// Depends on mbet_pkg for the coordinate and product widths.
module mbet_mul
(
    input  logic                                clk,
    input  logic signed [mbet_pkg::COORD_BITS-1:0] mul_a,
    input  logic signed [mbet_pkg::COORD_BITS-1:0] mul_b,
    output logic signed [mbet_pkg::PROD_W-1:0]     product
);
    import mbet_pkg::*;

    logic signed [PROD_W-1:0] product_reg;

    // One product per cycle, available the cycle after the operands.
    always_ff @(posedge clk)
    begin
        product_reg <= mul_a * mul_b;
    end

    assign product = product_reg;

endmodule

// File: rtl/mbet_seq.sv
`timescale 1ns / 1ps
// Sequencer and iteration datapath: forms c, runs z = z*z + c on the shared
// multiplier and holds the result word. Depends on mbet_pkg and mbet_mul.
module mbet_seq
#(
    parameter int MAX_SIDE = mbet_pkg::MAX_SIDE_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  mbet_pkg::cfg_t                    cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mbet_pkg::IDX_W-1:0]        column,
    input  logic [mbet_pkg::IDX_W-1:0]        line,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mbet_pkg::CNT_W-1:0]        iteration_count,
    output logic                              escaped,
    output logic signed [mbet_pkg::COORD_BITS-1:0] final_re,
    output logic signed [mbet_pkg::COORD_BITS-1:0] final_im
);
    import mbet_pkg::*;

    localparam logic [IDX_W:0]   SIDE_LIM = (IDX_W + 1)'(MAX_SIDE);
    localparam logic [IDX_W-1:0] IDX_MAX  = IDX_W'(MAX_SIDE - 1);

    state_t   state_reg;
    state_t   state_next;
    mul_sel_t mul_sel;
    logic     finish;

    logic [IDX_W-1:0]             col_reg;
    logic [IDX_W-1:0]             row_reg;
    logic signed [COORD_BITS-1:0] c_re_reg;
    logic signed [COORD_BITS-1:0] c_im_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [PROD_W-1:0]     xx_reg;
    logic signed [PROD_W-1:0]     diff_reg;
    logic                         stop_reg;
    logic [CNT_W-1:0]             count_reg;

    logic                         out_valid_reg;
    logic [CNT_W-1:0]             out_count_reg;
    logic                         out_escaped_reg;
    logic signed [COORD_BITS-1:0] out_re_reg;
    logic signed [COORD_BITS-1:0] out_im_reg;

    logic signed [COORD_BITS-1:0] mul_a;
    logic signed [COORD_BITS-1:0] mul_b;
    logic signed [PROD_W-1:0]     product;
    logic [PROD_W-1:0]            mag;
    logic                         accept;
    logic                         out_free;

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    // The loop ends when the stop flag is set and the result word is free.
    assign finish   = (state_reg == ST_UPDATE) && stop_reg && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_C_RE;
            ST_C_RE:   state_next = ST_C_IM;
            ST_C_IM:   state_next = ST_C_SUM;
            ST_C_SUM:  state_next = ST_SQ_X;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_CROSS;
            ST_CROSS:  state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!stop_reg)
                begin
                    state_next = ST_SQ_X;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: input handshake and multiplier operand choice.
    always_comb
    begin
        in_ready = 1'b0;
        mul_sel  = MUL_XX;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_C_RE:   mul_sel  = MUL_STEP_COL;
            ST_C_IM:   mul_sel  = MUL_STEP_ROW;
            ST_SQ_X:   mul_sel  = MUL_XX;
            ST_SQ_Y:   mul_sel  = MUL_YY;
            ST_CROSS:  mul_sel  = MUL_XY;
            default:   mul_sel  = MUL_XX;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (mul_sel)
            MUL_STEP_COL:
            begin
                mul_a = $signed({1'b0, cfg.step});
                mul_b = $signed(COORD_BITS'(col_reg));
            end
            MUL_STEP_ROW:
            begin
                mul_a = $signed({1'b0, cfg.step});
                mul_b = $signed(COORD_BITS'(row_reg));
            end
            MUL_YY:
            begin
                mul_a = y_reg;
                mul_b = y_reg;
            end
            MUL_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    mbet_mul u_mul
    (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    // Squares are non-negative, so their sum is taken unsigned.
    assign mag = $unsigned(xx_reg) + $unsigned(product);

    // Iteration datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= '0;
                    end
                end
                ST_CROSS:
                begin
                    stop_reg <= (mag > ESC_LIMIT) || (count_reg >= cfg.limit);
                end
                ST_UPDATE:
                begin
                    if (!stop_reg)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Coordinate registers; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    col_reg <= ({1'b0, column} >= SIDE_LIM) ? IDX_MAX : column;
                    row_reg <= ({1'b0, line} >= SIDE_LIM) ? IDX_MAX : line;
                    x_reg   <= '0;
                    y_reg   <= '0;
                end
            end
            ST_C_IM:
            begin
                c_re_reg <= sat_coord(SAT_W'(cfg.origin_re) + SAT_W'(product));
            end
            ST_C_SUM:
            begin
                c_im_reg <= sat_coord(SAT_W'(cfg.origin_im) + SAT_W'(product));
            end
            ST_SQ_Y:
            begin
                xx_reg <= product;
            end
            ST_CROSS:
            begin
                diff_reg <= xx_reg - product;
            end
            ST_UPDATE:
            begin
                if (!stop_reg)
                begin
                    x_reg <= sat_coord(SAT_W'(diff_reg >>> FRAC_BITS) + SAT_W'(c_re_reg));
                    y_reg <= sat_coord(SAT_W'(product >>> (FRAC_BITS - 1))
                                       + SAT_W'(c_im_reg));
                end
            end
            default: ;
        endcase
    end

    // Result word: filled at the end of a pixel, held until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_count_reg   <= count_reg;
            out_escaped_reg <= (count_reg < cfg.limit);
            out_re_reg      <= x_reg;
            out_im_reg      <= y_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign escaped         = out_escaped_reg;
    assign final_re        = out_re_reg;
    assign final_im        = out_im_reg;

endmodule

// File: rtl/mandelbrot_escape_time_pixel.sv
`timescale 1ns / 1ps
// Escape-time pixel engine, top level: stream packing around the sequencer.
// Depends on mbet_pkg, mbet_cfg, mbet_seq and mbet_mul.
//
// Usage: each input word on the s_axis channel carries a pixel column and row.
// The engine forms c = origin + step * index, iterates z = z*z + c from zero
// and returns one output word on the m_axis channel with the iteration count,
// the escaped flag and the final z. The cfg channel writes origin_re (0),
// origin_im (1), pixel_step (2) and iteration_limit (3); it is always ready
// and the user must write it only while no pixel is in flight; it is not enforced.
// Sequence: once a pixel is accepted the engine forms c_re and c_im, then runs
// the states SQ_X, SQ_Y, CROSS and UPDATE for each iteration until the escape
// test or the limit stops it, and the result goes into the output register.
// Each iteration uses the single shared multiplier three times and then
// updates z in a separate step, so the multiplier sets the
// rate. s_axis_tready is high only while the engine is idle, one pixel at a time.
// The finished word sits in an output register; the next pixel is accepted
// while it waits, and a pixel that finishes while the receiver still stalls
// holds in its last cycle until the register frees.
// Reset clears the registers to origin 0, step 0 and limit 100, and empties
// the output register.
module mandelbrot_escape_time_pixel
#(
    parameter int MAX_SIDE = mbet_pkg::MAX_SIDE_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mbet_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbet_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Pixel input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [23:0]                        s_axis_tdata,  // column[11:0], line[23:12]
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [79:0]                        m_axis_tdata   // iteration_count[11:0],
                                                              // escaped[12], final_re[44:13],
                                                              // final_im[76:45], zero[79:77]
);
    import mbet_pkg::*;

    cfg_t                     cfg;
    logic [CNT_W-1:0]         iteration_count;
    logic                     escaped;
    logic signed [COORD_BITS-1:0] final_re;
    logic signed [COORD_BITS-1:0] final_im;

    mbet_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbet_seq #(
        .MAX_SIDE (MAX_SIDE)
    ) u_seq
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .column          (s_axis_tdata[IDX_W-1:0]),
        .line            (s_axis_tdata[2*IDX_W-1:IDX_W]),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .iteration_count (iteration_count),
        .escaped         (escaped),
        .final_re        (final_re),
        .final_im        (final_im)
    );

    // Pack the result word, lowest field first, padded to whole bytes.
    assign m_axis_tdata = {3'b000, final_im, final_re, escaped, iteration_count};

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the escape-time pixel engine: a directed table, then random phases
// of register settings and pixels, each result checked against an in-bench escape-time model.
// Depends on mbet_pkg and the mandelbrot_escape_time_pixel top level.
module tb;
    import mbet_pkg::*;

    // Run length and safety limits.
    localparam int RANDOM_PIXELS = 1880;
    localparam int QUIET_TAIL    = 150;
    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int DRAIN_PAUSE   = 40;
    localparam int SIDE          = MAX_SIDE_DEF;

    // Q4.28 values used by the directed table.
    localparam logic [31:0] MINUS_TWO = 32'hE000_0000;
    localparam logic [31:0] COORD_TOP = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_BOT = 32'h8000_0000;
    localparam logic [30:0] STEP_MAX  = 31'h7FFF_FFFF;
    localparam logic [30:0] STEP_4K   = 31'h0004_0000;

    localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
    localparam longint COORD_MIN = -COORD_MAX - 64'sd1;
    localparam longint unsigned ESCAPE_BOUND = 64'd4 << (2 * FRAC_BITS);

    // One pixel word, column in the low bits.
    typedef struct packed {
        logic [IDX_W-1:0] line;
        logic [IDX_W-1:0] column;
    } pixel_t;

    // One result word, iteration count in the low bits.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] final_im;
        logic signed [COORD_BITS-1:0] final_re;
        logic                         escaped;
        logic [CNT_W-1:0]             iter_count;
    } result_t;

    typedef enum logic { ROW_SETTINGS, ROW_PIXEL } row_kind_t;

    // One row of the directed table.
    typedef struct {
        row_kind_t kind;
        cfg_t      settings;
        pixel_t    px;
        bit        typed;
        result_t   want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // column[11:0], line[23:12]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [79:0]           m_axis_tdata;   // iteration_count[11:0], escaped[12],
                                           // final_re[44:13], final_im[76:45], zero[79:77]

    cfg_t    live_cfg;
    result_t pending_results[$];
    row_t    plan[$];
    int      mismatches;
    int      results_seen;
    int      cycles;
    bit      sender_idles;
    bit      tail_quiet;

    mandelbrot_escape_time_pixel dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Clamp a wide value to the signed coordinate range.
    function automatic logic signed [COORD_BITS-1:0] clip_coord(longint v);
        if (v > COORD_MAX)
        begin
            return COORD_BITS'(COORD_MAX);
        end
        else if (v < COORD_MIN)
        begin
            return COORD_BITS'(COORD_MIN);
        end
        return COORD_BITS'(v);
    endfunction

    // Escape-time iteration for one pixel under the given register settings.
    function automatic result_t escape_time(cfg_t s, pixel_t px);
        longint           c_re;
        longint           c_im;
        longint           x;
        longint           y;
        longint           xx;
        longint           yy;
        longint           xy;
        longint unsigned  mag;
        int unsigned      n;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        bit               done;
        result_t          r;
        col  = (px.column >= SIDE) ? IDX_W'(SIDE - 1) : px.column;
        row  = (px.line >= SIDE) ? IDX_W'(SIDE - 1) : px.line;
        c_re = clip_coord(longint'($signed(s.origin_re)) + longint'(s.step) * longint'(col));
        c_im = clip_coord(longint'($signed(s.origin_im)) + longint'(s.step) * longint'(row));
        x    = 0;
        y    = 0;
        n    = 0;
        done = 1'b0;
        // The escape test uses the exact squares; the update floors and saturates.
        while (!done)
        begin
            xx  = x * x;
            yy  = y * y;
            xy  = x * y;
            mag = $unsigned(xx) + $unsigned(yy);
            if (mag > ESCAPE_BOUND || n >= s.limit)
            begin
                done = 1'b1;
            end
            else
            begin
                x = clip_coord(((xx - yy) >>> FRAC_BITS) + c_re);
                y = clip_coord((xy >>> (FRAC_BITS - 1)) + c_im);
                n++;
            end
        end
        r.iter_count = n[CNT_W-1:0];
        r.escaped    = (n < s.limit);
        r.final_re   = x[COORD_BITS-1:0];
        r.final_im   = y[COORD_BITS-1:0];
        return r;
    endfunction

    // Table builders.
    function automatic void plan_settings(logic [31:0] re, logic [31:0] im, logic [30:0] step,
                                          logic [11:0] limit);
        row_t r;
        r.kind     = ROW_SETTINGS;
        r.settings = '{origin_re: re, origin_im: im, step: step, limit: limit};
        r.px       = '0;
        r.typed    = 1'b0;
        r.want     = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_pixel(int col, int line);
        row_t r;
        r.kind     = ROW_PIXEL;
        r.settings = '0;
        r.px       = '{line: IDX_W'(line), column: IDX_W'(col)};
        r.typed    = 1'b0;
        r.want     = '0;
        plan.push_back(r);
    endfunction

    function automatic void plan_known(int col, int line, int count, bit esc,
                                       logic [31:0] re, logic [31:0] im);
        plan_pixel(col, line);
        plan[$].typed = 1'b1;
        plan[$].want  = '{final_im: im, final_re: re, escaped: esc,
                          iter_count: CNT_W'(count)};
    endfunction

    // Random pixel index, now and then pinned to an edge of the image.
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 15) == 0)
        begin
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return IDX_W'($urandom_range(0, SIDE - 1));
    endfunction

    // Write one register; valid stays high so that writes can follow back to back.
    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (r)
            CFG_ORIGIN_RE: live_cfg.origin_re = v;
            CFG_ORIGIN_IM: live_cfg.origin_im = v;
            CFG_STEP:      live_cfg.step      = v[STEP_W-1:0];
            CFG_LIMIT:     live_cfg.limit     = v[CNT_W-1:0];
            default:       ;
        endcase
    endtask

    // Let every pixel in flight come out, then load a full register set.
    task automatic apply_settings(cfg_t s);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // Bits above a register's width are filled at random; they must be ignored.
        write_reg(CFG_ORIGIN_RE, s.origin_re);
        write_reg(CFG_ORIGIN_IM, s.origin_im);
        write_reg(CFG_STEP, {1'($urandom), s.step});
        write_reg(CFG_LIMIT, {20'($urandom), s.limit});
        cfg_valid <= 1'b0;
    endtask

    // Offer one pixel word, with an optional idle burst ahead of it.
    task automatic send_pixel(pixel_t px, bit typed, result_t want);
        if (sender_idles && !tail_quiet && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(typed ? want : escape_time(live_cfg, px));
    endtask

    task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
    endtask

    // Compare one result word with the oldest expectation.
    task automatic check_result(result_t got, logic [2:0] pad);
        result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            $error("result word with no pixel waiting: 0x%0h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got.iter_count !== want.iter_count)
        begin
            flag_field("iteration_count", want.iter_count, got.iter_count);
        end
        if (got.escaped !== want.escaped)
        begin
            flag_field("escaped", want.escaped, got.escaped);
        end
        if (got.final_re !== want.final_re)
        begin
            flag_field("final_re", want.final_re, got.final_re);
        end
        if (got.final_im !== want.final_im)
        begin
            flag_field("final_im", want.final_im, got.final_im);
        end
        if (pad !== 3'b000)
        begin
            flag_field("padding", 32'd0, pad);
        end
    endtask

    // Receiver: checks each accepted word and drives tready with bursts of stalls,
    // calm stretches and now and then a long hold-off that backs up the input.
    initial
    begin
        int  stall_left;
        int  mode_left;
        int  hold_left;
        bit  calm;
        bit  ready_next;
        stall_left    = 0;
        mode_left     = 0;
        hold_left     = 0;
        calm          = 1'b0;
        results_seen  = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result(result_t'(m_axis_tdata[76:0]), m_axis_tdata[79:77]);
                results_seen++;
                if (results_seen % 700 == 40)
                begin
                    hold_left = 500;
                end
            end
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (tail_quiet)
            begin
                ready_next = 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    calm      = ($urandom_range(0, 2) == 0);
                    mode_left = $urandom_range(50, 400);
                end
                else
                begin
                    mode_left--;
                end
                if (stall_left != 0)
                begin
                    stall_left--;
                    ready_next = 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    stall_left = $urandom_range(1, 9) - 1;
                    ready_next = 1'b0;
                end
                else
                begin
                    ready_next = 1'b1;
                end
            end
            m_axis_tready <= ready_next;
        end
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // Stimulus: reset, the directed table, then random phases.
    initial
    begin
        cfg_t   s;
        pixel_t px;
        int     random_sent;
        int     n;
        int     pick;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= CFG_ORIGIN_RE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        mismatches    = 0;
        sender_idles  = 1'b1;
        tail_quiet    = 1'b0;
        random_sent   = 0;
        live_cfg      = '{origin_re: '0, origin_im: '0, step: '0, limit: LIMIT_RESET};

        // Values after reset: c is zero everywhere and the default limit is reached.
        plan_known(0, 0, 100, 1'b0, 32'd0, 32'd0);
        plan_known(4095, 4095, 100, 1'b0, 32'd0, 32'd0);
        plan_known(2730, 1365, 100, 1'b0, 32'd0, 32'd0);
        // A 4x4 view from -2-2i: the corner escapes at once, the centre never does.
        plan_settings(MINUS_TWO, MINUS_TWO, STEP_4K, 12'd100);
        plan_known(0, 0, 1, 1'b1, MINUS_TWO, MINUS_TWO);
        plan_known(2048, 2048, 100, 1'b0, 32'd0, 32'd0);
        plan_pixel(1024, 2048);
        plan_pixel(3072, 2048);
        plan_pixel(1536, 2560);
        plan_pixel(1000, 2300);
        plan_pixel(4095, 4095);
        // No iteration at all.
        plan_settings(MINUS_TWO, MINUS_TWO, STEP_4K, 12'd0);
        plan_known(2048, 2048, 0, 1'b0, 32'd0, 32'd0);
        plan_known(0, 0, 0, 1'b0, 32'd0, 32'd0);
        // Escape on the last allowed iteration does not count as escaped.
        plan_settings(MINUS_TWO, MINUS_TWO, STEP_4K, 12'd1);
        plan_known(0, 0, 1, 1'b0, MINUS_TWO, MINUS_TWO);
        plan_known(2048, 2048, 1, 1'b0, 32'd0, 32'd0);
        // Extreme origin and step: c saturates.
        plan_settings(COORD_TOP, COORD_BOT, STEP_MAX, 12'd4095);
        plan_known(4095, 4095, 1, 1'b1, COORD_TOP, COORD_TOP);
        plan_known(0, 0, 1, 1'b1, COORD_TOP, COORD_BOT);
        plan_pixel(1, 1);
        plan_settings(COORD_BOT, COORD_BOT, 31'd0, 12'd4095);
        plan_known(123, 456, 1, 1'b1, COORD_BOT, COORD_BOT);
        // Longest pixel: c at zero under the largest limit.
        plan_settings(32'd0, 32'd0, 31'd0, 12'd4095);
        plan_known(4095, 0, 4095, 1'b0, 32'd0, 32'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_SETTINGS)
            begin
                apply_settings(plan[i].settings);
            end
            else
            begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: mostly views over the interesting region, some pure noise.
        while (random_sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                s.origin_re = $urandom;
                s.origin_im = $urandom;
                s.step      = STEP_W'($urandom);
            end
            else
            begin
                s.origin_re = 32'd0 - 32'($urandom_range(1 << 28, 3 << 28));
                s.origin_im = 32'd0 - 32'($urandom_range(1 << 27, 5 << 27));
                s.step      = STEP_W'($urandom_range(1 << 13, 1 << 18));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                s.limit = CNT_W'($urandom_range(0, 3));
            end
            else if (pick == 1)
            begin
                s.limit = CNT_W'($urandom_range(128, 255));
            end
            else
            begin
                s.limit = CNT_W'($urandom_range(4, 64));
            end
            apply_settings(s);
            sender_idles = ($urandom_range(0, 2) != 0);
            n = $urandom_range(20, 120);
            for (int k = 0; k < n && random_sent < RANDOM_PIXELS; k++)
            begin
                px.column = pick_index();
                px.line   = pick_index();
                send_pixel(px, 1'b0, '0);
                random_sent++;
                tail_quiet = (random_sent >= RANDOM_PIXELS - QUIET_TAIL);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Wait for the last results, then a short pause for anything stray.
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAUSE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
